// File: sv/lwcd_pkg.sv
// lwcd_pkg: shared types and codes for the lru write-back cache directory
// no dependencies; used by lwcd_cell and lru_writeback_cache_directory_top

package lwcd_pkg;

  localparam int LBA_W = 48;

  // request function codes
  localparam logic [2:0] FN_READ      = 3'd0;
  localparam logic [2:0] FN_WRITE     = 3'd1;
  localparam logic [2:0] FN_INVAL     = 3'd2;
  localparam logic [2:0] FN_FLUSH_ONE = 3'd3;
  localparam logic [2:0] FN_FLUSH_ALL = 3'd4;

  // event counter indexes
  localparam int CNT_RD_HIT  = 0;
  localparam int CNT_RD_MISS = 1;
  localparam int CNT_WR_HIT  = 2;
  localparam int CNT_WR_MISS = 3;
  localparam int CNT_FLUSH   = 4;
  localparam int CNT_EVICT   = 5;
  localparam int N_CNT       = 6;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_VALID = 2'd1,
    ST_DIRTY = 2'd2
  } entry_st_t;

  // broadcast operations to the cell row
  typedef enum logic [2:0] {
    OP_NOP,
    OP_TOUCH,
    OP_REMOVE,
    OP_INSERT,
    OP_CLEAN,
    OP_CLEAN_ALL
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             mark_dirty;
    logic [LBA_W-1:0] lba;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [LBA_W-1:0] lba;
  } req_t;

  typedef struct packed {
    logic             status;
    logic [5:0]       slot;
    logic             victim_valid;
    logic [LBA_W-1:0] victim_lba;
    logic             victim_dirty;
    logic [6:0]       flushed_count;
    logic [31:0]      read_hit_total;
    logic [31:0]      read_miss_total;
    logic [31:0]      write_hit_total;
    logic [31:0]      write_miss_total;
    logic [31:0]      flush_total;
    logic [31:0]      eviction_total;
  } rsp_t;

endpackage

// File: sv/lwcd_cell.sv
// lwcd_cell: one directory slot holding address, entry state and recency rank
// depends on lwcd_pkg

module lwcd_cell #(
  parameter int RW = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lwcd_pkg::cell_cmd_t           cmd,
  input  logic [RW-1:0]                 ref_rank,
  input  logic                          sel,
  output logic                          match,
  output logic                          occ,
  output logic                          dirty,
  output logic [RW-1:0]                 rank,
  output logic [lwcd_pkg::LBA_W-1:0]    addr
);

  logic [lwcd_pkg::LBA_W-1:0] addr_r, addr_nxt;
  lwcd_pkg::entry_st_t        st_r, st_nxt;
  logic [RW-1:0]              rank_r, rank_nxt;

  assign occ   = (st_r != lwcd_pkg::ST_FREE);
  assign dirty = (st_r == lwcd_pkg::ST_DIRTY);
  assign match = occ && (addr_r == cmd.lba);
  assign rank  = rank_r;
  assign addr  = addr_r;

  // apply the broadcast operation
  always_comb begin
    addr_nxt = addr_r;
    st_nxt   = st_r;
    rank_nxt = rank_r;
    case (cmd.op)
      lwcd_pkg::OP_TOUCH: begin
        if (sel) begin
          rank_nxt = '0;
          if (cmd.mark_dirty) st_nxt = lwcd_pkg::ST_DIRTY;
        end else if (occ && rank_r < ref_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lwcd_pkg::OP_REMOVE: begin
        if (sel) begin
          st_nxt   = lwcd_pkg::ST_FREE;
          rank_nxt = '0;
        end else if (occ && rank_r > ref_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      lwcd_pkg::OP_INSERT: begin
        if (sel) begin
          addr_nxt = cmd.lba;
          st_nxt   = cmd.mark_dirty ? lwcd_pkg::ST_DIRTY : lwcd_pkg::ST_VALID;
          rank_nxt = '0;
        end else if (occ) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      lwcd_pkg::OP_CLEAN: begin
        if (sel && dirty) st_nxt = lwcd_pkg::ST_VALID;
      end
      lwcd_pkg::OP_CLEAN_ALL: begin
        if (dirty) st_nxt = lwcd_pkg::ST_VALID;
      end
      default: begin
      end
    endcase
  end

  // state and rank reset, address has none
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (!rst_n) begin
      st_r   <= lwcd_pkg::ST_FREE;
      rank_r <= '0;
    end else begin
      st_r   <= st_nxt;
      rank_r <= rank_nxt;
    end
  end

endmodule

// File: sv/lru_writeback_cache_directory_top.sv
// lru_writeback_cache_directory_top: fully associative lru write-back directory
// depends on lwcd_pkg and lwcd_cell (one cell per slot)
//
// channel   ports                          transfer
// request   start, busy, in_data           start high and busy low at clk
// result    out_strobe, out_data           out_strobe high for one cycle
// config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high at clk
//
// a write miss picks a free slot or the lru victim one key bit per cycle over
// the cell row, evicts the victim when no slot is free, then inserts. the
// result strobe cycle overlaps the next request transfer. synchronous
// active-low reset frees every slot and clears the counters. the result side
// has no back pressure.

module lru_writeback_cache_directory_top #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lwcd_pkg::req_t    in_data,
  output logic              out_strobe,
  output lwcd_pkg::rsp_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [6:0]        cfg_data
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int BW = (IW > 1) ? $clog2(IW) : 1;
  localparam int DW = $clog2(CAPACITY + 1);
  localparam int CW = (DW > 7) ? DW : 7;
  localparam logic [CW-1:0] CAP_MAX = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_DECIDE, S_SEARCH, S_EVICT, S_INSERT, S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [2:0]                 func_r, func_nxt;
  logic [lwcd_pkg::LBA_W-1:0] lba_r, lba_nxt;
  logic [CAPACITY-1:0]        sel_r, sel_nxt;
  logic                       lru_mode_r, lru_mode_nxt;
  logic [BW-1:0]              bit_r, bit_nxt;
  logic [CW-1:0]              cap_r;
  logic [DW-1:0]              dirty_cnt_r, dirty_cnt_nxt;
  logic [31:0]                cnt_r [lwcd_pkg::N_CNT];
  logic [31:0]                cnt_nxt [lwcd_pkg::N_CNT];
  logic                       res_status_r, res_status_nxt;
  logic [IW-1:0]              res_slot_r, res_slot_nxt;
  logic                       res_vval_r, res_vval_nxt;
  logic [lwcd_pkg::LBA_W-1:0] res_vlba_r, res_vlba_nxt;
  logic                       res_vdirty_r, res_vdirty_nxt;
  logic [DW-1:0]              res_flushed_r, res_flushed_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  lwcd_pkg::rsp_t             out_data_r, out_data_nxt;

  lwcd_pkg::cell_cmd_t        cmd;
  logic [CAPACITY-1:0]        c_match, c_occ, c_dirty, below, keybit;
  logic [IW-1:0]              c_rank [CAPACITY];
  logic [lwcd_pkg::LBA_W-1:0] c_addr [CAPACITY];
  logic [IW-1:0]              sel_rank, sel_idx;
  logic [lwcd_pkg::LBA_W-1:0] sel_addr;
  logic                       sel_dirty, any_key;
  logic [CW-1:0]              eff_cap;

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // clamp capacity in use to 1..CAPACITY
  always_comb begin
    eff_cap = cap_r;
    if (cap_r == '0) eff_cap = CW'(1);
    else if (cap_r > CAP_MAX) eff_cap = CAP_MAX;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IW-1:0] IDX = IW'(i);
    lwcd_cell #(.RW(IW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .ref_rank (sel_rank),
      .sel      (sel_r[i]),
      .match    (c_match[i]),
      .occ      (c_occ[i]),
      .dirty    (c_dirty[i]),
      .rank     (c_rank[i]),
      .addr     (c_addr[i])
    );
    assign below[i]  = (CW'(i) < eff_cap);
    // lru search prefers high rank, free search prefers low index
    assign keybit[i] = lru_mode_r ? c_rank[i][bit_r] : ~IDX[bit_r];
  end

  // gather the selected cell's fields
  always_comb begin
    sel_rank  = '0;
    sel_idx   = '0;
    sel_addr  = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_r[i]) begin
        sel_rank  = sel_rank | c_rank[i];
        sel_idx   = sel_idx | IW'(i);
        sel_addr  = sel_addr | c_addr[i];
        sel_dirty = sel_dirty | c_dirty[i];
      end
    end
  end

  assign any_key = |(sel_r & keybit);

  // request sequencer
  always_comb begin
    state_nxt       = state_r;
    func_nxt        = func_r;
    lba_nxt         = lba_r;
    sel_nxt         = sel_r;
    lru_mode_nxt    = lru_mode_r;
    bit_nxt         = bit_r;
    dirty_cnt_nxt   = dirty_cnt_r;
    cnt_nxt         = cnt_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_vval_nxt    = res_vval_r;
    res_vlba_nxt    = res_vlba_r;
    res_vdirty_nxt  = res_vdirty_r;
    res_flushed_nxt = res_flushed_r;
    out_strobe_nxt  = 1'b0;
    out_data_nxt    = out_data_r;
    cmd.op          = lwcd_pkg::OP_NOP;
    cmd.mark_dirty  = 1'b0;
    cmd.lba         = lba_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_data.func;
          lba_nxt   = in_data.lba;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        sel_nxt         = c_match;
        res_status_nxt  = 1'b1;
        res_slot_nxt    = '0;
        res_vval_nxt    = 1'b0;
        res_vlba_nxt    = '0;
        res_vdirty_nxt  = 1'b0;
        res_flushed_nxt = '0;
        state_nxt       = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        case (func_r)
          lwcd_pkg::FN_READ: begin
            if (|sel_r) begin
              cmd.op = lwcd_pkg::OP_TOUCH;
              res_status_nxt = 1'b0;
              res_slot_nxt   = sel_idx;
              cnt_nxt[lwcd_pkg::CNT_RD_HIT] = cnt_r[lwcd_pkg::CNT_RD_HIT] + 32'd1;
            end else begin
              cnt_nxt[lwcd_pkg::CNT_RD_MISS] = cnt_r[lwcd_pkg::CNT_RD_MISS] + 32'd1;
            end
          end
          lwcd_pkg::FN_WRITE: begin
            if (|sel_r) begin
              cmd.op         = lwcd_pkg::OP_TOUCH;
              cmd.mark_dirty = 1'b1;
              res_status_nxt = 1'b0;
              res_slot_nxt   = sel_idx;
              if (!sel_dirty) dirty_cnt_nxt = dirty_cnt_r + 1'b1;
              cnt_nxt[lwcd_pkg::CNT_WR_HIT] = cnt_r[lwcd_pkg::CNT_WR_HIT] + 32'd1;
            end else begin
              cnt_nxt[lwcd_pkg::CNT_WR_MISS] = cnt_r[lwcd_pkg::CNT_WR_MISS] + 32'd1;
              if (|(~c_occ & below)) begin
                sel_nxt      = ~c_occ & below;
                lru_mode_nxt = 1'b0;
              end else begin
                sel_nxt      = below;
                lru_mode_nxt = 1'b1;
              end
              bit_nxt   = BW'(IW - 1);
              state_nxt = S_SEARCH;
            end
          end
          lwcd_pkg::FN_INVAL: begin
            if (|sel_r) begin
              cmd.op         = lwcd_pkg::OP_REMOVE;
              res_status_nxt = 1'b0;
              if (sel_dirty) dirty_cnt_nxt = dirty_cnt_r - 1'b1;
            end
          end
          lwcd_pkg::FN_FLUSH_ONE: begin
            if (|sel_r) begin
              res_status_nxt = 1'b0;
              res_slot_nxt   = sel_idx;
              if (sel_dirty) begin
                cmd.op          = lwcd_pkg::OP_CLEAN;
                dirty_cnt_nxt   = dirty_cnt_r - 1'b1;
                res_flushed_nxt = DW'(1);
                cnt_nxt[lwcd_pkg::CNT_FLUSH] = cnt_r[lwcd_pkg::CNT_FLUSH] + 32'd1;
              end
            end
          end
          lwcd_pkg::FN_FLUSH_ALL: begin
            cmd.op          = lwcd_pkg::OP_CLEAN_ALL;
            res_status_nxt  = 1'b0;
            res_flushed_nxt = dirty_cnt_r;
            dirty_cnt_nxt   = '0;
            cnt_nxt[lwcd_pkg::CNT_FLUSH] = cnt_r[lwcd_pkg::CNT_FLUSH] + 32'(dirty_cnt_r);
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        // narrow candidates one key bit per cycle, msb first
        if (any_key) sel_nxt = sel_r & keybit;
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) state_nxt = lru_mode_r ? S_EVICT : S_INSERT;
      end
      S_EVICT: begin
        cmd.op         = lwcd_pkg::OP_REMOVE;
        res_vval_nxt   = 1'b1;
        res_vlba_nxt   = sel_addr;
        res_vdirty_nxt = sel_dirty;
        if (sel_dirty) begin
          dirty_cnt_nxt = dirty_cnt_r - 1'b1;
          cnt_nxt[lwcd_pkg::CNT_FLUSH] = cnt_r[lwcd_pkg::CNT_FLUSH] + 32'd1;
        end
        cnt_nxt[lwcd_pkg::CNT_EVICT] = cnt_r[lwcd_pkg::CNT_EVICT] + 32'd1;
        state_nxt = S_INSERT;
      end
      S_INSERT: begin
        cmd.op         = lwcd_pkg::OP_INSERT;
        cmd.mark_dirty = 1'b1;
        res_slot_nxt   = sel_idx;
        dirty_cnt_nxt  = dirty_cnt_r + 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        out_strobe_nxt                = 1'b1;
        out_data_nxt.status           = res_status_r;
        out_data_nxt.slot             = 6'(res_slot_r);
        out_data_nxt.victim_valid     = res_vval_r;
        out_data_nxt.victim_lba       = res_vlba_r;
        out_data_nxt.victim_dirty     = res_vdirty_r;
        out_data_nxt.flushed_count    = 7'(res_flushed_r);
        out_data_nxt.read_hit_total   = cnt_r[lwcd_pkg::CNT_RD_HIT];
        out_data_nxt.read_miss_total  = cnt_r[lwcd_pkg::CNT_RD_MISS];
        out_data_nxt.write_hit_total  = cnt_r[lwcd_pkg::CNT_WR_HIT];
        out_data_nxt.write_miss_total = cnt_r[lwcd_pkg::CNT_WR_MISS];
        out_data_nxt.flush_total      = cnt_r[lwcd_pkg::CNT_FLUSH];
        out_data_nxt.eviction_total   = cnt_r[lwcd_pkg::CNT_EVICT];
        state_nxt                     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk) begin
    func_r        <= func_nxt;
    lba_r         <= lba_nxt;
    sel_r         <= sel_nxt;
    lru_mode_r    <= lru_mode_nxt;
    bit_r         <= bit_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_vval_r    <= res_vval_nxt;
    res_vlba_r    <= res_vlba_nxt;
    res_vdirty_r  <= res_vdirty_nxt;
    res_flushed_r <= res_flushed_nxt;
    out_data_r    <= out_data_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CAP_MAX;
      dirty_cnt_r  <= '0;
      out_strobe_r <= 1'b0;
      for (int k = 0; k < lwcd_pkg::N_CNT; k++) cnt_r[k] <= '0;
    end else begin
      state_r      <= state_nxt;
      dirty_cnt_r  <= dirty_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_valid && cfg_ready) cap_r <= CW'(cfg_data);
    end
  end

endmodule

// File: verif/tb.sv
// tb: self-checking testbench for lru_writeback_cache_directory_top
// depends on lwcd_pkg and the rtl under sv/; a scoreboard class predicts each result

module tb;

  localparam int CAP = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  // directory predictor plus queue of expected results
  class dir_scoreboard;
    logic [lwcd_pkg::LBA_W-1:0] addr [CAP];
    lwcd_pkg::entry_st_t        st [CAP];
    int unsigned                rank [CAP];
    logic [31:0]                cnt [lwcd_pkg::N_CNT];
    int unsigned                cap_reg;
    lwcd_pkg::rsp_t             pending [$];
    int                         errors;

    function new();
      for (int i = 0; i < CAP; i++) begin
        addr[i] = '0;
        st[i] = lwcd_pkg::ST_FREE;
        rank[i] = 0;
      end
      for (int i = 0; i < lwcd_pkg::N_CNT; i++) cnt[i] = '0;
      cap_reg = CAP;
      errors = 0;
    endfunction

    function void set_capacity(logic [6:0] v);
      cap_reg = v;
    endfunction

    function int lookup(logic [lwcd_pkg::LBA_W-1:0] a);
      for (int i = 0; i < CAP; i++)
        if (st[i] != lwcd_pkg::ST_FREE && addr[i] == a) return i;
      return -1;
    endfunction

    function void promote(int s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < CAP; i++)
        if (st[i] != lwcd_pkg::ST_FREE && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void drop(int s);
      int unsigned r;
      r = rank[s];
      for (int i = 0; i < CAP; i++)
        if (st[i] != lwcd_pkg::ST_FREE && rank[i] > r) rank[i]--;
      st[s] = lwcd_pkg::ST_FREE;
      rank[s] = 0;
    endfunction

    function void place(int s, logic [lwcd_pkg::LBA_W-1:0] a);
      for (int i = 0; i < CAP; i++)
        if (st[i] != lwcd_pkg::ST_FREE) rank[i]++;
      addr[s] = a;
      st[s] = lwcd_pkg::ST_VALID;
      rank[s] = 0;
    endfunction

    // note one accepted request and queue its expected result
    function void note_request(lwcd_pkg::req_t rq);
      lwcd_pkg::rsp_t r;
      int s, pick, cap;
      int unsigned best;
      int unsigned fl;
      r = '0;
      r.status = 1'b1;
      fl = 0;
      case (rq.func)
        lwcd_pkg::FN_READ: begin
          s = lookup(rq.lba);
          if (s >= 0) begin
            promote(s);
            r.status = 1'b0;
            r.slot = s[5:0];
            cnt[lwcd_pkg::CNT_RD_HIT]++;
          end else cnt[lwcd_pkg::CNT_RD_MISS]++;
        end
        lwcd_pkg::FN_WRITE: begin
          s = lookup(rq.lba);
          if (s >= 0) begin
            promote(s);
            r.status = 1'b0;
            cnt[lwcd_pkg::CNT_WR_HIT]++;
          end else begin
            cap = cap_reg;
            if (cap < 1) cap = 1;
            if (cap > CAP) cap = CAP;
            pick = -1;
            for (int i = 0; i < cap; i++)
              if (pick < 0 && st[i] == lwcd_pkg::ST_FREE) pick = i;
            if (pick < 0) begin
              best = 0;
              pick = 0;
              for (int i = 0; i < cap; i++)
                if (rank[i] >= best) begin
                  best = rank[i];
                  pick = i;
                end
              r.victim_valid = 1'b1;
              r.victim_lba = addr[pick];
              r.victim_dirty = (st[pick] == lwcd_pkg::ST_DIRTY);
              if (r.victim_dirty) cnt[lwcd_pkg::CNT_FLUSH]++;
              cnt[lwcd_pkg::CNT_EVICT]++;
              drop(pick);
            end
            place(pick, rq.lba);
            s = pick;
            cnt[lwcd_pkg::CNT_WR_MISS]++;
          end
          st[s] = lwcd_pkg::ST_DIRTY;
          r.slot = s[5:0];
        end
        lwcd_pkg::FN_INVAL: begin
          s = lookup(rq.lba);
          if (s >= 0) begin
            drop(s);
            r.status = 1'b0;
          end
        end
        lwcd_pkg::FN_FLUSH_ONE: begin
          s = lookup(rq.lba);
          if (s >= 0) begin
            r.status = 1'b0;
            r.slot = s[5:0];
            if (st[s] == lwcd_pkg::ST_DIRTY) begin
              st[s] = lwcd_pkg::ST_VALID;
              fl = 1;
            end
          end
          cnt[lwcd_pkg::CNT_FLUSH] += fl;
        end
        lwcd_pkg::FN_FLUSH_ALL: begin
          for (int i = 0; i < CAP; i++)
            if (st[i] == lwcd_pkg::ST_DIRTY) begin
              st[i] = lwcd_pkg::ST_VALID;
              fl++;
            end
          r.status = 1'b0;
          cnt[lwcd_pkg::CNT_FLUSH] += fl;
        end
        default: ;
      endcase
      r.flushed_count = fl[6:0];
      r.read_hit_total = cnt[lwcd_pkg::CNT_RD_HIT];
      r.read_miss_total = cnt[lwcd_pkg::CNT_RD_MISS];
      r.write_hit_total = cnt[lwcd_pkg::CNT_WR_HIT];
      r.write_miss_total = cnt[lwcd_pkg::CNT_WR_MISS];
      r.flush_total = cnt[lwcd_pkg::CNT_FLUSH];
      r.eviction_total = cnt[lwcd_pkg::CNT_EVICT];
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
    endtask

    // compare one strobed result against the oldest expectation
    task check_result(lwcd_pkg::rsp_t g);
      lwcd_pkg::rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected result", g.status, 0);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", g.status, e.status);
      if (g.slot !== e.slot) report("slot", g.slot, e.slot);
      if (g.victim_valid !== e.victim_valid)
        report("victim_valid", g.victim_valid, e.victim_valid);
      if (g.victim_lba !== e.victim_lba) report("victim_lba", g.victim_lba, e.victim_lba);
      if (g.victim_dirty !== e.victim_dirty)
        report("victim_dirty", g.victim_dirty, e.victim_dirty);
      if (g.flushed_count !== e.flushed_count)
        report("flushed_count", g.flushed_count, e.flushed_count);
      if (g.read_hit_total !== e.read_hit_total)
        report("read_hit_total", g.read_hit_total, e.read_hit_total);
      if (g.read_miss_total !== e.read_miss_total)
        report("read_miss_total", g.read_miss_total, e.read_miss_total);
      if (g.write_hit_total !== e.write_hit_total)
        report("write_hit_total", g.write_hit_total, e.write_hit_total);
      if (g.write_miss_total !== e.write_miss_total)
        report("write_miss_total", g.write_miss_total, e.write_miss_total);
      if (g.flush_total !== e.flush_total)
        report("flush_total", g.flush_total, e.flush_total);
      if (g.eviction_total !== e.eviction_total)
        report("eviction_total", g.eviction_total, e.eviction_total);
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  lwcd_pkg::req_t in_data;
  logic           out_strobe;
  lwcd_pkg::rsp_t out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [6:0]     cfg_data;

  dir_scoreboard sb;
  int idle_cycles;
  logic [lwcd_pkg::LBA_W-1:0] addr_pool [16];

  lru_writeback_cache_directory_top #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor and watchdog on idle cycles
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_data);
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL lru_writeback_cache_directory_top");
      $finish;
    end
  end

  // start stays high across back-to-back transfers and drops only for a gap or a drain
  task automatic send_request(logic [2:0] fn, logic [lwcd_pkg::LBA_W-1:0] a);
    int gap;
    lwcd_pkg::req_t rq;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      in_data <= {3'd0, 48'($urandom()) ^ {16'($urandom()), 32'd0}};
      repeat (gap) @(posedge clk);
    end
    rq.func = fn;
    rq.lba = a;
    start <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(rq);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_capacity(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [lwcd_pkg::LBA_W-1:0] rand_lba();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // random phase over a small address pool so hits and evictions are common
  task automatic random_phase(int n);
    logic [2:0] fn;
    logic [lwcd_pkg::LBA_W-1:0] a;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) fn = lwcd_pkg::FN_WRITE;
      else if (pick < 70) fn = lwcd_pkg::FN_READ;
      else if (pick < 80) fn = lwcd_pkg::FN_INVAL;
      else if (pick < 90) fn = lwcd_pkg::FN_FLUSH_ONE;
      else if (pick < 95) fn = lwcd_pkg::FN_FLUSH_ALL;
      else fn = 3'($urandom_range(0, 7));
      a = ($urandom_range(0, 9) == 0) ? rand_lba() : addr_pool[$urandom_range(0, 15)];
      send_request(fn, a);
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    for (int i = 0; i < 16; i++) addr_pool[i] = rand_lba();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every function, unknown codes, small capacity
    send_request(lwcd_pkg::FN_READ, '0);
    send_request(lwcd_pkg::FN_WRITE, '0);
    send_request(lwcd_pkg::FN_WRITE, '1);
    send_request(lwcd_pkg::FN_READ, '1);
    send_request(lwcd_pkg::FN_WRITE, '0);
    send_request(lwcd_pkg::FN_FLUSH_ONE, '0);
    send_request(lwcd_pkg::FN_FLUSH_ONE, '0);
    send_request(lwcd_pkg::FN_FLUSH_ONE, 48'h123);
    send_request(lwcd_pkg::FN_FLUSH_ALL, '0);
    send_request(3'd5, '1);
    send_request(3'd6, '0);
    send_request(3'd7, '1);
    send_request(lwcd_pkg::FN_INVAL, '1);
    send_request(lwcd_pkg::FN_INVAL, '1);
    write_capacity(7'd1);
    send_request(lwcd_pkg::FN_WRITE, 48'h5);
    send_request(lwcd_pkg::FN_WRITE, 48'h6);
    send_request(lwcd_pkg::FN_READ, 48'h5);
    send_request(lwcd_pkg::FN_READ, '0);
    write_capacity(7'd0);
    send_request(lwcd_pkg::FN_WRITE, 48'h7);
    send_request(lwcd_pkg::FN_FLUSH_ALL, '1);

    // sender holds off until the directory is fully drained
    wait_drained();
    write_capacity(7'd127);
    random_phase(300);
    write_capacity(7'd4);
    random_phase(400);
    write_capacity(7'd64);
    random_phase(300);
    write_capacity(7'd13);
    random_phase(400);
    write_capacity(7'($urandom_range(1, 64)));
    random_phase(430);

    wait_drained();
    if (sb.errors == 0) begin
      $display("PASS lru_writeback_cache_directory_top");
    end else begin
      $display("FAIL lru_writeback_cache_directory_top");
    end
    $finish;
  end
endmodule
